[sv/eflha_pkg.sv]
`timescale 1ns / 1ps

package eflha_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CHUNK_W = 17;
  localparam int unsigned REQ_W   = 16;
  localparam int unsigned ADDR_W  = 16;

  // smallest block that can sit on the free list
  localparam logic [WORD_W-1:0] MIN_BLOCK   = 32'd24;
  localparam logic [WORD_W-1:0] ALIGN_MASK  = 32'hFFFF_FFF8;
  localparam logic [WORD_W-1:0] WORD_MASK   = 32'hFFFF_FFFC;
  localparam logic [WORD_W-1:0] ALLOC_BIT   = 32'd1;
  localparam logic [WORD_W-1:0] PROLOGUE_HF = 32'd9;
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 17'd4096;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  // datapath micro-operations, one per controller step
  typedef enum logic [5:0] {
    OP_NONE, OP_ACCEPT, OP_DISP,
    OP_I0, OP_I1, OP_I2, OP_I3, OP_I4, OP_I5, OP_I6,
    OP_FF_CHK, OP_FF_TST, OP_FF_NEXT, OP_AG, OP_A1,
    OP_G0, OP_G1, OP_G2, OP_G3,
    OP_M0, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6, OP_M7,
    OP_U0, OP_U1, OP_U2, OP_U3,
    OP_P0, OP_P1, OP_P2,
    OP_C0, OP_C1, OP_C2, OP_C3, OP_C4, OP_C5, OP_C6, OP_C7,
    OP_OUT
  } op_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic       req_zero;
    logic       blk_zero;
    logic       brk_low;
    logic       p_zero;
    logic       fits;
    logic       walk_over;
    logic       rd_free;
    logic       grow_ovf;
    logic       ok;
    logic       split;
    logic       out_busy;
  } dp_stat_t;

endpackage

[sv/eflha_ram.sv]
`timescale 1ns / 1ps

module eflha_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[sv/eflha_ctrl.sv]
`timescale 1ns / 1ps

module eflha_ctrl import eflha_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output op_e      op_o
);

  localparam int unsigned SN = 43;

  typedef enum logic [SN-1:0] {
    S_IDLE = 43'(1) << 0,  S_DISP = 43'(1) << 1,
    S_I0   = 43'(1) << 2,  S_I1   = 43'(1) << 3,  S_I2 = 43'(1) << 4,
    S_I3   = 43'(1) << 5,  S_I4   = 43'(1) << 6,  S_I5 = 43'(1) << 7,
    S_I6   = 43'(1) << 8,
    S_FF1  = 43'(1) << 9,  S_FF2  = 43'(1) << 10, S_FF3 = 43'(1) << 11,
    S_AG   = 43'(1) << 12, S_A1   = 43'(1) << 13,
    S_G0   = 43'(1) << 14, S_G1   = 43'(1) << 15, S_G2 = 43'(1) << 16,
    S_G3   = 43'(1) << 17,
    S_M0   = 43'(1) << 18, S_M1   = 43'(1) << 19, S_M2 = 43'(1) << 20,
    S_M3   = 43'(1) << 21, S_M4   = 43'(1) << 22, S_M5 = 43'(1) << 23,
    S_M6   = 43'(1) << 24, S_M7   = 43'(1) << 25, S_M8 = 43'(1) << 26,
    S_U0   = 43'(1) << 27, S_U1   = 43'(1) << 28, S_U2 = 43'(1) << 29,
    S_U3   = 43'(1) << 30,
    S_P0   = 43'(1) << 31, S_P1   = 43'(1) << 32, S_P2 = 43'(1) << 33,
    S_C0   = 43'(1) << 34, S_C1   = 43'(1) << 35, S_C2 = 43'(1) << 36,
    S_C3   = 43'(1) << 37, S_C4   = 43'(1) << 38, S_C5 = 43'(1) << 39,
    S_C6   = 43'(1) << 40, S_C7   = 43'(1) << 41,
    S_DONE = 43'(1) << 42
  } state_e;

  state_e state_q, state_d;
  // return points for the unlink/push, merge and grow sequences
  state_e leaf_ret_q, leaf_ret_d;
  state_e merge_ret_q, merge_ret_d;
  state_e grow_ret_q, grow_ret_d;

  assign in_ready_o = (state_q == S_IDLE);

  // map each step onto its datapath operation
  always_comb begin
    case (state_q)
      S_IDLE: op_o = in_valid_i ? OP_ACCEPT : OP_NONE;
      S_DISP: op_o = OP_DISP;
      S_I0:   op_o = OP_I0;
      S_I1:   op_o = OP_I1;
      S_I2:   op_o = OP_I2;
      S_I3:   op_o = OP_I3;
      S_I4:   op_o = OP_I4;
      S_I5:   op_o = OP_I5;
      S_I6:   op_o = OP_I6;
      S_FF1:  op_o = OP_FF_CHK;
      S_FF2:  op_o = OP_FF_TST;
      S_FF3:  op_o = OP_FF_NEXT;
      S_AG:   op_o = OP_AG;
      S_A1:   op_o = OP_A1;
      S_G0:   op_o = OP_G0;
      S_G1:   op_o = OP_G1;
      S_G2:   op_o = OP_G2;
      S_G3:   op_o = OP_G3;
      S_M0:   op_o = OP_M0;
      S_M1:   op_o = OP_M1;
      S_M2:   op_o = OP_M2;
      S_M3:   op_o = OP_M3;
      S_M4:   op_o = OP_M4;
      S_M5:   op_o = OP_M5;
      S_M6:   op_o = OP_M6;
      S_M7:   op_o = OP_M7;
      S_U0:   op_o = OP_U0;
      S_U1:   op_o = OP_U1;
      S_U2:   op_o = OP_U2;
      S_U3:   op_o = OP_U3;
      S_P0:   op_o = OP_P0;
      S_P1:   op_o = OP_P1;
      S_P2:   op_o = OP_P2;
      S_C0:   op_o = OP_C0;
      S_C1:   op_o = OP_C1;
      S_C2:   op_o = OP_C2;
      S_C3:   op_o = OP_C3;
      S_C4:   op_o = OP_C4;
      S_C5:   op_o = OP_C5;
      S_C6:   op_o = OP_C6;
      S_C7:   op_o = OP_C7;
      S_DONE: op_o = OP_OUT;
      default: op_o = OP_NONE;
    endcase
  end

  // sequence the command
  always_comb begin
    state_d     = state_q;
    leaf_ret_d  = leaf_ret_q;
    merge_ret_d = merge_ret_q;
    grow_ret_d  = grow_ret_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DISP;
      S_DISP: begin
        case (stat_i.cmd)
          CMD_INIT: state_d = S_I0;
          CMD_ALLOC: begin
            state_d = (stat_i.req_zero || stat_i.brk_low) ? S_DONE : S_FF1;
          end
          CMD_FREE: begin
            if (stat_i.blk_zero || stat_i.brk_low) begin
              state_d = S_DONE;
            end else begin
              merge_ret_d = S_DONE;
              state_d     = S_M0;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_I0: state_d = S_I1;
      S_I1: state_d = S_I2;
      S_I2: state_d = S_I3;
      S_I3: state_d = S_I4;
      S_I4: state_d = S_I5;
      S_I5: begin
        grow_ret_d = S_I6;
        state_d    = S_G0;
      end
      S_I6: state_d = S_DONE;
      // first-fit walk
      S_FF1: state_d = stat_i.p_zero ? S_AG : S_FF2;
      S_FF2: begin
        if (stat_i.fits) state_d = S_C0;
        else if (stat_i.walk_over) state_d = S_AG;
        else state_d = S_FF3;
      end
      S_FF3: state_d = S_FF1;
      S_AG: begin
        grow_ret_d = S_A1;
        state_d    = S_G0;
      end
      S_A1: state_d = stat_i.ok ? S_C0 : S_DONE;
      // grow the break
      S_G0: state_d = stat_i.grow_ovf ? grow_ret_q : S_G1;
      S_G1: state_d = S_G2;
      S_G2: begin
        merge_ret_d = S_G3;
        state_d     = S_M0;
      end
      S_G3: state_d = grow_ret_q;
      // coalesce and push
      S_M0: state_d = S_M1;
      S_M1: state_d = S_M2;
      S_M2: state_d = S_M3;
      S_M3: begin
        if (stat_i.rd_free) begin
          leaf_ret_d = S_M4;
          state_d    = S_U0;
        end else begin
          state_d = S_M4;
        end
      end
      S_M4: state_d = S_M5;
      S_M5: begin
        if (stat_i.rd_free) begin
          leaf_ret_d = S_M6;
          state_d    = S_U0;
        end else begin
          state_d = S_M6;
        end
      end
      S_M6: state_d = S_M7;
      S_M7: begin
        leaf_ret_d = S_M8;
        state_d    = S_P0;
      end
      S_M8: state_d = merge_ret_q;
      S_U0: state_d = S_U1;
      S_U1: state_d = S_U2;
      S_U2: state_d = S_U3;
      S_U3: state_d = leaf_ret_q;
      S_P0: state_d = S_P1;
      S_P1: state_d = S_P2;
      S_P2: state_d = leaf_ret_q;
      // take the chosen block, split off the remainder
      S_C0: state_d = S_C1;
      S_C1: begin
        leaf_ret_d = S_C2;
        state_d    = S_U0;
      end
      S_C2: state_d = stat_i.split ? S_C3 : S_C6;
      S_C3: state_d = S_C4;
      S_C4: state_d = S_C5;
      S_C5: begin
        leaf_ret_d = S_C7;
        state_d    = S_P0;
      end
      S_C6: state_d = S_C7;
      S_C7: state_d = S_DONE;
      S_DONE: if (!stat_i.out_busy) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      leaf_ret_q  <= S_IDLE;
      merge_ret_q <= S_IDLE;
      grow_ret_q  <= S_IDLE;
    end else begin
      state_q     <= state_d;
      leaf_ret_q  <= leaf_ret_d;
      merge_ret_q <= merge_ret_d;
      grow_ret_q  <= grow_ret_d;
    end
  end

endmodule

[sv/eflha_dp.sv]
`timescale 1ns / 1ps

module eflha_dp import eflha_pkg::*; #(
  parameter int unsigned HEAP_BYTES = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  op_e                op_i,
  output dp_stat_t           stat_o,
  input  logic [1:0]         in_command_i,
  input  logic [REQ_W-1:0]   in_request_size_i,
  input  logic [ADDR_W-1:0]  in_block_address_i,
  input  logic               cfg_we_i,
  input  logic [CHUNK_W-1:0] cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ADDR_W-1:0]  out_address_o,
  output logic [1:0]         out_status_o
);

  localparam int unsigned AW         = $clog2(HEAP_BYTES);
  localparam int unsigned BW         = AW + 1;
  localparam int unsigned DEPTH      = HEAP_BYTES / 4;
  localparam int unsigned WALK_LIMIT = HEAP_BYTES / 24 + 1;
  localparam int unsigned NW         = $clog2(WALK_LIMIT + 1);

  // heap state and configuration
  logic [BW-1:0]      brk_q, brk_d;
  logic [WORD_W-1:0]  head_q, head_d;
  logic [CHUNK_W-1:0] chunk_q;
  logic               out_valid_q;

  // working registers
  logic [1:0]        cmd_q;
  logic              req_zero_q, blk_zero_q, ok_q;
  logic [WORD_W-1:0] need_q, p_q, q_q, x_q, nx_q, pv_q, total_q;
  logic [WORD_W-1:0] after_q, before_q, old_q, rest_q, bs_q, tmp_q;
  logic [NW-1:0]     n_q;
  logic [1:0]        st_q;
  logic [WORD_W-1:0] addr_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [1:0]        out_st_q;

  // memory port
  logic              mem_we, mem_re;
  logic [WORD_W-1:0] mem_woff, mem_wdata, mem_roff, rd;

  logic [WORD_W-1:0] sz, brk32, bs, rest, chunk32, need_in;
  logic              ovf, split, fits, walk_over, out_busy;

  assign brk32     = WORD_W'(brk_q);
  assign chunk32   = WORD_W'(chunk_q);
  assign sz        = rd & ALIGN_MASK;
  assign bs        = (((tmp_q & WORD_MASK) + 32'd7) & ALIGN_MASK) + MIN_BLOCK;
  assign ovf       = ({1'b0, brk32} + {1'b0, bs}) > (WORD_W + 1)'(HEAP_BYTES);
  assign rest      = old_q - need_q;
  assign split     = rest >= MIN_BLOCK;
  assign fits      = sz >= need_q;
  assign walk_over = n_q >= NW'(WALK_LIMIT);
  assign out_busy  = out_valid_q && !out_ready_i;
  assign need_in   = (((WORD_W'(in_request_size_i)) + 32'd7) & ALIGN_MASK) + 32'd16;

  assign stat_o = '{cmd: cmd_q, req_zero: req_zero_q, blk_zero: blk_zero_q,
                    brk_low: brk32 < MIN_BLOCK, p_zero: p_q == '0, fits: fits,
                    walk_over: walk_over, rd_free: ~rd[0], grow_ovf: ovf,
                    ok: ok_q, split: split, out_busy: out_busy};

  eflha_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_woff[AW-1:2]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_roff[AW-1:2]),
    .rdata_o (rd)
  );

  // drive the memory port for each step
  always_comb begin
    mem_we    = 1'b0;
    mem_woff  = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_roff  = '0;
    case (op_i)
      OP_I0: begin mem_we = 1'b1; mem_woff = 32'd0; end
      OP_I1: begin mem_we = 1'b1; mem_woff = 32'd4; end
      OP_I2: begin mem_we = 1'b1; mem_woff = 32'd8; end
      OP_I3: begin mem_we = 1'b1; mem_woff = 32'd12; mem_wdata = PROLOGUE_HF; end
      OP_I4: begin mem_we = 1'b1; mem_woff = 32'd16; mem_wdata = PROLOGUE_HF; end
      OP_I5: begin mem_we = 1'b1; mem_woff = 32'd20; mem_wdata = ALLOC_BIT; end
      OP_FF_CHK: begin mem_re = (p_q != '0); mem_roff = p_q - 32'd4; end
      OP_FF_TST: begin mem_re = !fits && !walk_over; mem_roff = p_q; end
      OP_G0: begin
        mem_we = !ovf; mem_woff = brk32 - 32'd4; mem_wdata = bs;
      end
      OP_G1: begin mem_we = 1'b1; mem_woff = p_q + bs_q - 32'd8; mem_wdata = bs_q; end
      OP_G2: begin mem_we = 1'b1; mem_woff = p_q + bs_q - 32'd4; mem_wdata = ALLOC_BIT; end
      OP_M0: begin mem_re = 1'b1; mem_roff = p_q - 32'd4; end
      OP_M1: begin mem_re = 1'b1; mem_roff = p_q - 32'd8; end
      OP_M2: begin mem_re = 1'b1; mem_roff = after_q - 32'd4; end
      OP_M4: begin mem_re = 1'b1; mem_roff = before_q - 32'd4; end
      OP_M6: begin mem_we = 1'b1; mem_woff = p_q - 32'd4; mem_wdata = total_q; end
      OP_M7: begin
        mem_we = 1'b1; mem_woff = p_q + total_q - 32'd8; mem_wdata = total_q;
      end
      OP_U0: begin mem_re = 1'b1; mem_roff = x_q; end
      OP_U1: begin mem_re = 1'b1; mem_roff = x_q + 32'd8; end
      OP_U2: begin mem_we = (nx_q != '0); mem_woff = nx_q + 32'd8; mem_wdata = rd; end
      OP_U3: begin mem_we = (pv_q != '0); mem_woff = pv_q; mem_wdata = nx_q; end
      OP_P0: begin mem_we = 1'b1; mem_woff = x_q + 32'd8; end
      OP_P1: begin mem_we = 1'b1; mem_woff = x_q; mem_wdata = head_q; end
      OP_P2: begin mem_we = (head_q != '0); mem_woff = head_q + 32'd8; mem_wdata = x_q; end
      OP_C0: begin mem_re = 1'b1; mem_roff = p_q - 32'd4; end
      OP_C2: begin
        mem_we = 1'b1; mem_woff = p_q - 32'd4;
        mem_wdata = split ? (need_q | ALLOC_BIT) : (old_q | ALLOC_BIT);
      end
      OP_C3: begin
        mem_we = 1'b1; mem_woff = p_q + need_q - 32'd8; mem_wdata = need_q | ALLOC_BIT;
      end
      OP_C4: begin mem_we = 1'b1; mem_woff = q_q - 32'd4; mem_wdata = rest_q; end
      OP_C5: begin
        mem_we = 1'b1; mem_woff = q_q + rest_q - 32'd8; mem_wdata = rest_q;
      end
      OP_C6: begin
        mem_we = 1'b1; mem_woff = p_q + old_q - 32'd8; mem_wdata = old_q | ALLOC_BIT;
      end
      default: ;
    endcase
  end

  // break and list head
  always_comb begin
    brk_d  = brk_q;
    head_d = head_q;
    case (op_i)
      OP_I5: begin
        brk_d  = BW'(MIN_BLOCK);
        head_d = '0;
      end
      OP_G0: if (!ovf) brk_d = BW'(brk32 + bs);
      OP_U3: if (pv_q == '0) head_d = nx_q;
      OP_P2: head_d = x_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brk_q       <= '0;
      head_q      <= '0;
      chunk_q     <= CHUNK_RESET;
      out_valid_q <= 1'b0;
    end else begin
      brk_q  <= brk_d;
      head_q <= head_d;
      if (cfg_we_i) chunk_q <= cfg_wdata_i;
      if (op_i == OP_OUT && !out_busy) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // working registers, updated per step
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_ACCEPT: begin
        cmd_q      <= in_command_i;
        need_q     <= need_in;
        req_zero_q <= (in_request_size_i == '0);
        blk_zero_q <= (in_block_address_i == '0);
        p_q        <= WORD_W'(in_block_address_i);
        st_q       <= ST_OK;
        addr_q     <= '0;
      end
      OP_DISP: begin
        case (cmd_q)
          CMD_INIT: ;
          CMD_ALLOC: begin
            p_q <= head_q;
            n_q <= '0;
            if (req_zero_q) st_q <= ST_IGNORED;
            else if (brk32 < MIN_BLOCK) st_q <= ST_NOMEM;
          end
          CMD_FREE: if (blk_zero_q || brk32 < MIN_BLOCK) st_q <= ST_IGNORED;
          default: st_q <= ST_IGNORED;
        endcase
      end
      OP_I5:      tmp_q <= chunk32;
      OP_I6:      if (!ok_q) st_q <= ST_NOMEM;
      OP_FF_TST:  if (!fits) n_q <= n_q + 1'b1;
      OP_FF_NEXT: p_q <= rd;
      OP_AG:      tmp_q <= (need_q > chunk32) ? need_q : chunk32;
      OP_A1:      if (!ok_q) st_q <= ST_NOMEM;
      OP_G0: begin
        if (ovf) begin
          ok_q <= 1'b0;
        end else begin
          p_q  <= brk32;
          bs_q <= bs;
        end
      end
      OP_G3: ok_q <= (p_q != '0);
      OP_M1: begin
        total_q <= sz;
        after_q <= p_q + sz;
      end
      OP_M2: before_q <= p_q - sz;
      OP_M3: begin
        if (!rd[0]) total_q <= total_q + sz;
        x_q <= after_q;
      end
      OP_M5: begin
        if (!rd[0]) begin
          total_q <= total_q + sz;
          p_q     <= before_q;
        end
        x_q <= before_q;
      end
      OP_M7: x_q <= p_q;
      OP_U1: nx_q <= rd;
      OP_U2: pv_q <= rd;
      OP_C1: begin
        old_q <= sz;
        x_q   <= p_q;
      end
      OP_C2: begin
        rest_q <= rest;
        q_q    <= p_q + need_q;
      end
      OP_C5: x_q <= q_q;
      OP_C7: addr_q <= p_q;
      OP_OUT: begin
        if (!out_busy) begin
          out_addr_q <= addr_q[ADDR_W-1:0];
          out_st_q   <= st_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign out_address_o = out_addr_q;
  assign out_status_o  = out_st_q;

endmodule

[sv/explicit_free_list_heap_allocator_unit.sv]
// Ignored requests go straight to the result; free coalesces and pushes the block;
// initialize writes the prologue and grows the heap once; allocate walks the free list
// and grows the heap when no listed block fits. One item at a time, one heap word access
// a cycle; the next item is taken the cycle after the result is loaded, and loading waits
// while the previous result is still held. Reset clears the break, the list head and the
// handshakes and sets the chunk size to 4096; the heap memory is not cleared.
`timescale 1ns / 1ps

module explicit_free_list_heap_allocator_unit import eflha_pkg::*; #(
  parameter int unsigned HEAP_BYTES = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,  // request_size[15:0], block_address[31:16]
  input  logic [1:0]         s_axis_tuser,  // command[1:0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,  // address[15:0]
  output logic [1:0]         m_axis_tuser,  // status[1:0]
  input  logic               cfg_we_i,
  input  logic [CHUNK_W-1:0] cfg_wdata_i
);

  op_e      op;
  dp_stat_t stat;

  eflha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .op_o       (op)
  );

  eflha_dp #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .op_i               (op),
    .stat_o             (stat),
    .in_command_i       (s_axis_tuser),
    .in_request_size_i  (s_axis_tdata[15:0]),
    .in_block_address_i (s_axis_tdata[31:16]),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .out_valid_o        (m_axis_tvalid),
    .out_ready_i        (m_axis_tready),
    .out_address_o      (m_axis_tdata),
    .out_status_o       (m_axis_tuser)
  );

endmodule
